### hdl/bsaa_pkg.sv
// Shared types, constants and helpers for the bilateral slice affine apply block.
// Used by every module under hdl/; depends on nothing else.
package bsaa_pkg;

	// Defaults for the top-level size parameters.
	localparam int DEF_MAX_GRID_W    = 16;
	localparam int DEF_MAX_GRID_H    = 16;
	localparam int DEF_MAX_GRID_D    = 8;
	localparam int DEF_MAX_IN_CHANS  = 4;
	localparam int DEF_MAX_OUT_CHANS = 4;
	localparam int DEF_MAX_IMAGE_DIM = 4096;

	// Corner base addresses are bounded by the register widths (5-bit grid sizes,
	// 4-bit depth, at most 31 words per cell), so 20 bits always hold them.
	localparam int BASE_W      = 20;
	// Corner weights are Q16 and reach 1.0, hence 17 bits.
	localparam int WGT_W       = 17;
	localparam int QUEUE_DEPTH = 2;

	// Input command codes.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_GRID_WIDTH   = 3'd2;
	localparam logic [2:0] REG_GRID_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_GRID_DEPTH   = 3'd4;
	localparam logic [2:0] REG_IN_CHANS     = 3'd5;
	localparam logic [2:0] REG_OUT_CHANS    = 3'd6;
	localparam logic [2:0] REG_OFFSET_EN    = 3'd7;

	// Configuration after range saturation, plus derived channel counts.
	typedef struct packed {
		logic [12:0] iw;
		logic [12:0] ih;
		logic [4:0]  gw;
		logic [4:0]  gh;
		logic [3:0]  gd;
		logic [2:0]  ic;
		logic [2:0]  oc;
		logic        off;
		logic [2:0]  stride;
		logic [4:0]  gch;
	} cfg_t;

	// One queued job: either a grid word write or a prepared pixel.
	typedef struct packed {
		logic                         is_pix;
		logic [15:0]                  waddr;
		logic signed [23:0]           wdata;
		logic [7:0][BASE_W-1:0]       base;
		logic [7:0][WGT_W-1:0]        wgt;
		logic [3:0][15:0]             smp;
	} job_t;

	// Clamp a signed corner index into 0..n-1.
	function automatic logic [4:0] clamp_idx(input logic signed [18:0] lo,
			input logic [4:0] n);
		logic [4:0] r;
		if (lo < 19'sd0) begin
			r = 5'd0;
		end else if (lo >= $signed({14'd0, n})) begin
			r = n - 5'd1;
		end else begin
			r = lo[4:0];
		end
		return r;
	endfunction

endpackage

### hdl/bsaa_queue.sv
// Short job queue between the front and back parts of the slice block.
// Depends on bsaa_pkg for the job type and depth.
module bsaa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  bsaa_pkg::job_t  push_job,
	output logic            pop_valid,
	input  logic            pop_ready,
	output bsaa_pkg::job_t  pop_job
);
	import bsaa_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = ent_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/bsaa_front.sv
// Front part: accepts items, splits pixel positions into corners and weights.
// Depends on bsaa_pkg; feeds prepared jobs to bsaa_queue.
module bsaa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  bsaa_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [15:0]         grid_addr,
	input  logic signed [23:0]  grid_value,
	input  logic [11:0]         pixel_x,
	input  logic [11:0]         pixel_y,
	input  logic [15:0]         guide_value,
	input  logic signed [15:0]  in_chan0,
	input  logic signed [15:0]  in_chan1,
	input  logic signed [15:0]  in_chan2,
	input  logic signed [15:0]  in_chan3,
	output logic                push_valid,
	input  logic                push_ready,
	output bsaa_pkg::job_t      push_job
);
	import bsaa_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_DIV  = 4'b0010,
		F_CRN  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t            state_q;
	logic [5:0]         cnt_q;
	logic [33:0]        dx_q;
	logic [33:0]        dy_q;
	logic [13:0]        remx_q;
	logic [13:0]        remy_q;
	logic signed [20:0] pz_q;
	job_t               job_q;
	logic [9:0]         cxy_q;
	logic [33:0]        wxy_q;
	logic [13:0]        cell_q;

	logic               accept;
	logic [17:0]        numx;
	logic [17:0]        numy;
	logic signed [20:0] pz_n;
	logic [14:0]        denx;
	logic [14:0]        deny;
	logic [14:0]        rnx;
	logic [14:0]        rny;
	logic               gex;
	logic               gey;
	logic signed [18:0] lox;
	logic signed [18:0] loy;
	logic signed [18:0] loz;
	logic [4:0]         cx0, cx1, cy0, cy1, cz0, cz1;
	logic [16:0]        wx0, wx1, wy0, wy1, wz0, wz1;
	logic [2:0]         crn;
	logic [1:0]         phase;
	logic [4:0]         cxs, cys, czs;
	logic [16:0]        wxs, wys, wzs;
	logic [50:0]        wfull;

	assign in_ready   = (state_q == F_IDLE);
	assign accept     = in_valid && in_ready;
	assign push_valid = (state_q == F_PUSH);
	assign push_job   = job_q;

	// Numerators shifted by one denominator so the division stays unsigned.
	assign numx = ({5'd0, pixel_x, 1'b1} * {13'd0, cfg.gw}) + {5'd0, cfg.iw};
	assign numy = ({5'd0, pixel_y, 1'b1} * {13'd0, cfg.gh}) + {5'd0, cfg.ih};
	assign pz_n = $signed({1'b0, ({4'd0, guide_value} * {16'd0, cfg.gd})}) - 21'sd32768;

	// One restoring division step per cycle on each axis.
	assign denx = {1'b0, cfg.iw, 1'b0};
	assign deny = {1'b0, cfg.ih, 1'b0};
	assign rnx  = {remx_q, dx_q[33]};
	assign rny  = {remy_q, dy_q[33]};
	assign gex  = (rnx >= denx);
	assign gey  = (rny >= deny);

	// Lower corners; the quotient is one cell high because of the shift.
	assign lox = $signed({1'b0, dx_q[33:16]}) - 19'sd1;
	assign loy = $signed({1'b0, dy_q[33:16]}) - 19'sd1;
	assign loz = {{14{pz_q[20]}}, pz_q[20:16]};
	assign cx0 = clamp_idx(lox, cfg.gw);
	assign cx1 = clamp_idx(lox + 19'sd1, cfg.gw);
	assign cy0 = clamp_idx(loy, cfg.gh);
	assign cy1 = clamp_idx(loy + 19'sd1, cfg.gh);
	assign cz0 = clamp_idx(loz, {1'b0, cfg.gd});
	assign cz1 = clamp_idx(loz + 19'sd1, {1'b0, cfg.gd});
	assign wx1 = {1'b0, dx_q[15:0]};
	assign wy1 = {1'b0, dy_q[15:0]};
	assign wz1 = {1'b0, pz_q[15:0]};
	assign wx0 = 17'h10000 - wx1;
	assign wy0 = 17'h10000 - wy1;
	assign wz0 = 17'h10000 - wz1;

	// Corner selection: bit 0 picks x, bit 1 picks y, bit 2 picks z.
	assign crn   = cnt_q[4:2];
	assign phase = cnt_q[1:0];
	assign cxs   = crn[0] ? cx1 : cx0;
	assign cys   = crn[1] ? cy1 : cy0;
	assign czs   = crn[2] ? cz1 : cz0;
	assign wxs   = crn[0] ? wx1 : wx0;
	assign wys   = crn[1] ? wy1 : wy0;
	assign wzs   = crn[2] ? wz1 : wz0;
	assign wfull = {17'd0, wxy_q} * {34'd0, wzs};

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= (cmd == CMD_PIXEL) ? F_DIV : F_PUSH;
					end
				end
				F_DIV: begin
					if (cnt_q == 6'd33) begin
						cnt_q   <= '0;
						state_q <= F_CRN;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				F_CRN: begin
					if (cnt_q == 6'd31) begin
						cnt_q   <= '0;
						state_q <= F_PUSH;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Datapath: capture, divide, then build each corner's weight and base address in turn.
	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.is_pix <= (cmd == CMD_PIXEL);
			job_q.waddr  <= grid_addr;
			job_q.wdata  <= grid_value;
			job_q.smp    <= {in_chan3, in_chan2, in_chan1, in_chan0};
			dx_q         <= {numx, 16'd0};
			dy_q         <= {numy, 16'd0};
			remx_q       <= '0;
			remy_q       <= '0;
			pz_q         <= pz_n;
		end else if (state_q == F_DIV) begin
			remx_q <= gex ? 14'(rnx - denx) : rnx[13:0];
			remy_q <= gey ? 14'(rny - deny) : rny[13:0];
			dx_q   <= {dx_q[32:0], gex};
			dy_q   <= {dy_q[32:0], gey};
		end else if (state_q == F_CRN) begin
			unique case (phase)
				2'd0: begin
					cxy_q <= {5'd0, cxs} + ({5'd0, cys} * {5'd0, cfg.gw});
					wxy_q <= {17'd0, wxs} * {17'd0, wys};
				end
				2'd1: begin
					cell_q         <= {9'd0, czs} + ({10'd0, cfg.gd} * {4'd0, cxy_q});
					job_q.wgt[crn] <= wfull[48:32];
				end
				2'd2: begin
					job_q.base[crn] <= {6'd0, cell_q} * {15'd0, cfg.gch};
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/bsaa_back.sv
// Back part: grid store, corner sequencer and multiply-accumulate pipeline.
// Depends on bsaa_pkg; takes jobs from bsaa_queue and drives the result channel.
module bsaa_back #(
	parameter int STORE_DEPTH = 40960
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bsaa_pkg::cfg_t      cfg,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  bsaa_pkg::job_t      head,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_channel,
	output logic signed [31:0]  out_value,
	output logic                last
);
	import bsaa_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_RUN  = 2'b10
	} bstate_t;

	// Position of one read within its pixel.
	typedef struct packed {
		logic       firstn;
		logic       lastn;
		logic [2:0] k;
		logic       firstk;
		logic       lastk;
		logic [1:0] c;
		logic       lastc;
	} tag_t;

	logic signed [23:0] grid_mem_q [STORE_DEPTH];

	bstate_t            state_q;
	job_t               job_q;
	logic [2:0]         n_q;
	logic [4:0]         j_q;
	logic [2:0]         k_q;
	logic [1:0]         c_q;
	logic               chan_busy_q;
	logic               v_s1, v_s2, v_s3, v_s4;
	tag_t               tag_s1, tag_s2, tag_s3, tag_s4;
	logic [WGT_W-1:0]   w_s1;
	logic signed [23:0] rdata_s1;
	logic signed [41:0] prod_s2;
	logic signed [44:0] coeff_q;
	logic signed [44:0] coeff_s3;
	logic signed [16:0] smp_s3;
	logic signed [61:0] term_s4;
	logic signed [63:0] acc_q;
	logic               out_valid_q;
	logic [1:0]         out_channel_q;
	logic signed [31:0] out_value_q;
	logic               last_q;

	logic               pop;
	logic               wr_en;
	logic [BASE_W-1:0]  rd_sum;
	logic [AW-1:0]      rd_addr;
	logic               start_ch;
	logic               issue;
	logic               last_n;
	logic               last_k;
	logic               last_c;
	tag_t               tag_n;
	logic signed [44:0] coeff_sum;
	logic signed [63:0] acc_sum;
	logic signed [35:0] q16;
	logic signed [31:0] q16_sat;
	logic               land;

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign out_value   = out_value_q;
	assign last        = last_q;

	// Writes run whenever the sequencer is idle; a pixel waits for the pipe to drain.
	assign pop       = (state_q == B_IDLE) && pop_valid && (!head.is_pix || !chan_busy_q);
	assign pop_ready = pop;
	assign wr_en     = pop && !head.is_pix && ({16'd0, head.waddr} < 32'(STORE_DEPTH));

	// A channel starts only when the result register is free for it.
	assign start_ch = (n_q == 3'd0) && (k_q == 3'd0);
	assign issue    = (state_q == B_RUN) && !(start_ch && (chan_busy_q || out_valid_q));
	assign last_n   = (n_q == 3'd7);
	assign last_k   = (k_q == cfg.stride - 3'd1);
	assign last_c   = ({1'b0, c_q} == cfg.oc - 3'd1);
	assign rd_sum   = job_q.base[n_q] + BASE_W'(j_q);
	assign rd_addr  = AW'(rd_sum);

	always_comb begin
		tag_n.firstn = (n_q == 3'd0);
		tag_n.lastn  = last_n;
		tag_n.k      = k_q;
		tag_n.firstk = (k_q == 3'd0);
		tag_n.lastk  = last_k;
		tag_n.c      = c_q;
		tag_n.lastc  = last_c;
	end

	// Grid store with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem_q[AW'(head.waddr)] <= head.wdata;
		end
		rdata_s1 <= grid_mem_q[rd_addr];
	end

	// Sequencer over channels, coefficients and corners.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			n_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			c_q     <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop && head.is_pix) begin
						state_q <= B_RUN;
						n_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						c_q     <= '0;
					end
				end
				B_RUN: begin
					if (issue) begin
						if (!last_n) begin
							n_q <= n_q + 3'd1;
						end else begin
							n_q <= '0;
							j_q <= j_q + 5'd1;
							if (!last_k) begin
								k_q <= k_q + 3'd1;
							end else begin
								k_q <= '0;
								if (last_c) begin
									state_q <= B_IDLE;
								end else begin
									c_q <= c_q + 2'd1;
								end
							end
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Job held for the whole pixel.
	always_ff @(posedge clk) begin
		if (pop && head.is_pix) begin
			job_q <= head;
		end
	end

	// Arithmetic stages: weight product, corner sum, input product, channel sum.
	assign coeff_sum = (tag_s2.firstn ? 45'sd0 : coeff_q) + 45'(prod_s2);
	assign acc_sum   = (tag_s4.firstk ? 64'sd0 : acc_q) + 64'(term_s4);
	assign q16       = acc_sum[63:28];
	assign land      = v_s4 && tag_s4.lastk;

	always_comb begin
		if (q16 > 36'sh07FFFFFFF) begin
			q16_sat = 32'sh7FFFFFFF;
		end else if (q16 < -36'sh080000000) begin
			q16_sat = -32'sh80000000;
		end else begin
			q16_sat = q16[31:0];
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= tag_n;
		w_s1    <= job_q.wgt[n_q];
		tag_s2  <= tag_s1;
		prod_s2 <= 42'(rdata_s1) * 42'($signed({1'b0, w_s1}));
		if (v_s2) begin
			coeff_q <= coeff_sum;
		end
		tag_s3   <= tag_s2;
		coeff_s3 <= coeff_sum;
		smp_s3   <= ({1'b0, tag_s2.k} < {1'b0, cfg.ic}) ?
			17'($signed(job_q.smp[tag_s2.k[1:0]])) : 17'sd4096;
		tag_s4  <= tag_s3;
		term_s4 <= 62'(coeff_s3) * 62'(smp_s3);
		if (v_s4) begin
			acc_q <= acc_sum;
		end
		if (land) begin
			out_channel_q <= tag_s4.c;
			out_value_q   <= q16_sat;
			last_q        <= tag_s4.lastc;
		end
	end

	// Stage valids, channel tracking and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			chan_busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && tag_s2.lastn;
			v_s4 <= v_s3;
			if (issue && start_ch) begin
				chan_busy_q <= 1'b1;
			end else if (land) begin
				chan_busy_q <= 1'b0;
			end
			if (land) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	// A finished channel never overwrites a result still waiting.
	a_land_free: assert property (@(posedge clk) disable iff (!arst_n)
		land |-> !out_valid_q) else $error("result landed on a full output register");

	// Every finished channel was announced when its first read went out.
	a_land_busy: assert property (@(posedge clk) disable iff (!arst_n)
		land |-> chan_busy_q) else $error("result landed with no channel in flight");

	// Once idle with no channel in flight, the pipeline holds nothing.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE && !chan_busy_q) |-> !(v_s1 || v_s2 || v_s3 || v_s4))
		else $error("pipeline busy while sequencer idle");
`endif

endmodule

### hdl/bilateral_slice_affine_apply_core.sv
// Top level of the bilateral slice affine apply block: configuration registers
// and the front, queue and back parts. Depends on bsaa_pkg and all hdl modules.
//
// Usage. Configuration beats on cfg_valid/cfg_ready (always ready) write
// register cfg_index with cfg_data; write them only while the block is idle.
// Input beats on in_valid/in_ready carry cmd and its fields. A grid write
// (cmd 0) goes through the job queue and lands in the grid store in order
// with pixels; it gives no result. A pixel (cmd 1) gives one result beat per
// output channel on out_valid/out_ready, channel 0 first, last set on the
// final one.
// Timing. The front takes one item at a time: a pixel occupies it for a
// 34-step division of both axes, then one pass per corner; a grid write
// skips both and is pushed to the queue. The back reads one grid word and
// does one multiply-accumulate per cycle while a channel runs, but holds
// before each new channel until the previous one has landed and the result
// register is free. At reset settings the back sets the sustained rate. A
// two-entry queue lets the front prepare the next pixel while the back
// works.
// Reset clears all control state and loads the register defaults; the grid
// store is not cleared. When the receiver stalls, the result stays on the
// output register and the back holds before its next channel.
module bilateral_slice_affine_apply_core
	import bsaa_pkg::DEF_MAX_GRID_W, bsaa_pkg::DEF_MAX_GRID_H, bsaa_pkg::DEF_MAX_GRID_D,
		bsaa_pkg::DEF_MAX_IN_CHANS, bsaa_pkg::DEF_MAX_OUT_CHANS,
		bsaa_pkg::DEF_MAX_IMAGE_DIM;
#(
	parameter int MAX_GRID_W    = DEF_MAX_GRID_W,
	parameter int MAX_GRID_H    = DEF_MAX_GRID_H,
	parameter int MAX_GRID_D    = DEF_MAX_GRID_D,
	parameter int MAX_IN_CHANS  = DEF_MAX_IN_CHANS,
	parameter int MAX_OUT_CHANS = DEF_MAX_OUT_CHANS,
	parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [15:0]        grid_addr,
	input  logic signed [23:0] grid_value,
	input  logic [11:0]        pixel_x,
	input  logic [11:0]        pixel_y,
	input  logic [15:0]        guide_value,
	input  logic signed [15:0] in_chan0,
	input  logic signed [15:0] in_chan1,
	input  logic signed [15:0] in_chan2,
	input  logic signed [15:0] in_chan3,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_channel,
	output logic signed [31:0] out_value,
	output logic               last
);
	import bsaa_pkg::*;

	localparam int STORE_DEPTH =
		MAX_GRID_W * MAX_GRID_H * MAX_GRID_D * (MAX_IN_CHANS + 1) * MAX_OUT_CHANS;

	logic [12:0] iw_q;
	logic [12:0] ih_q;
	logic [4:0]  gw_q;
	logic [4:0]  gh_q;
	logic [3:0]  gd_q;
	logic [2:0]  ic_q;
	logic [2:0]  oc_q;
	logic        off_q;
	cfg_t        cfg;
	logic        push_valid;
	logic        push_ready;
	job_t        push_job;
	logic        pop_valid;
	logic        pop_ready;
	job_t        head;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q  <= 13'd1024;
			ih_q  <= 13'd1024;
			gw_q  <= 5'd16;
			gh_q  <= 5'd16;
			gd_q  <= 4'd8;
			ic_q  <= 3'd3;
			oc_q  <= 3'd3;
			off_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  iw_q  <= cfg_data;
				REG_IMAGE_HEIGHT: ih_q  <= cfg_data;
				REG_GRID_WIDTH:   gw_q  <= cfg_data[4:0];
				REG_GRID_HEIGHT:  gh_q  <= cfg_data[4:0];
				REG_GRID_DEPTH:   gd_q  <= cfg_data[3:0];
				REG_IN_CHANS:     ic_q  <= cfg_data[2:0];
				REG_OUT_CHANS:    oc_q  <= cfg_data[2:0];
				REG_OFFSET_EN:    off_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Range saturation of the registers and derived channel counts.
	always_comb begin
		cfg.iw = (iw_q == '0) ? 13'd1 :
			((int'(iw_q) > MAX_IMAGE_DIM) ? 13'(MAX_IMAGE_DIM) : iw_q);
		cfg.ih = (ih_q == '0) ? 13'd1 :
			((int'(ih_q) > MAX_IMAGE_DIM) ? 13'(MAX_IMAGE_DIM) : ih_q);
		cfg.gw = (gw_q == '0) ? 5'd1 :
			((int'(gw_q) > MAX_GRID_W) ? 5'(MAX_GRID_W) : gw_q);
		cfg.gh = (gh_q == '0) ? 5'd1 :
			((int'(gh_q) > MAX_GRID_H) ? 5'(MAX_GRID_H) : gh_q);
		cfg.gd = (gd_q == '0) ? 4'd1 :
			((int'(gd_q) > MAX_GRID_D) ? 4'(MAX_GRID_D) : gd_q);
		cfg.ic = (ic_q == '0) ? 3'd1 :
			((int'(ic_q) > MAX_IN_CHANS) ? 3'(MAX_IN_CHANS) : ic_q);
		cfg.oc = (oc_q == '0) ? 3'd1 :
			((int'(oc_q) > MAX_OUT_CHANS) ? 3'(MAX_OUT_CHANS) : oc_q);
		cfg.off    = off_q;
		cfg.stride = cfg.ic + {2'd0, off_q};
		cfg.gch    = 5'({2'd0, cfg.oc} * {2'd0, cfg.stride});
	end

	bsaa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.grid_addr   (grid_addr),
		.grid_value  (grid_value),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.guide_value (guide_value),
		.in_chan0    (in_chan0),
		.in_chan1    (in_chan1),
		.in_chan2    (in_chan2),
		.in_chan3    (in_chan3),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_job    (push_job)
	);

	bsaa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (head)
	);

	bsaa_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.head        (head),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_channel (out_channel),
		.out_value   (out_value),
		.last        (last)
	);

endmodule
